>>> sv/apgas_pkg.sv
`default_nettype none
package apgas_pkg;

    localparam int ENTRIES_DEF    = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int CFG_RESET_VAL  = 1024;

    // operation codes
    localparam logic OP_SET_ONE = 1'b0;
    localparam logic OP_SET_ALL = 1'b1;

    typedef struct packed {
        logic clear;   // write a zero word at the sweep address
        logic accept;  // capture the input word and launch the ram read
        logic exec;    // apply the captured word
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> sv/apgas_ram.sv
`default_nettype none
module apgas_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> sv/apgas_ctrl.sv
`default_nettype none
module apgas_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire apgas_pkg::t_dp_stat i_stat,
    output apgas_pkg::t_dp_cmd      o_cmd,
    output logic                    o_busy
);
    import apgas_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.clear  = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.exec   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

>>> sv/apgas_dp.sv
`default_nettype none
module apgas_dp #(
    parameter int ENTRIES    = apgas_pkg::ENTRIES_DEF,
    parameter int VALUE_BITS = apgas_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire apgas_pkg::t_dp_cmd                  i_cmd,
    output apgas_pkg::t_dp_stat                      o_stat,
    input  wire logic                                i_cfg_we,
    input  wire logic [$clog2(ENTRIES):0]            i_cfg_wdata,
    input  wire logic                                i_operation,
    input  wire logic [$clog2(ENTRIES)-1:0]          i_index,
    input  wire logic [VALUE_BITS-1:0]               i_value,
    output logic                                     o_done,
    output logic [VALUE_BITS+$clog2(ENTRIES)-1:0]    o_total,
    output logic                                     o_bad_index
);
    import apgas_pkg::*;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int GEN_W   = 32;
    localparam int TOTAL_W = VALUE_BITS + IDX_W;
    localparam int WORD_W  = GEN_W + VALUE_BITS;
    localparam int CFG_RST = (ENTRIES < CFG_RESET_VAL) ? ENTRIES : CFG_RESET_VAL;

    logic [IDX_W-1:0]      r_clr_addr;
    logic [CNT_W-1:0]      r_cfg;
    logic                  r_op;
    logic [IDX_W-1:0]      r_idx;
    logic [VALUE_BITS-1:0] r_val;
    logic [GEN_W-1:0]      r_gen;
    logic [VALUE_BITS-1:0] r_gval;
    logic [TOTAL_W-1:0]    r_total;
    logic                  r_done;
    logic [TOTAL_W-1:0]    r_out_total;
    logic                  r_out_bad;

    logic [CNT_W-1:0]         count;
    logic                     bad;
    logic [WORD_W-1:0]        rdata;
    logic [GEN_W-1:0]         rd_gen;
    logic [VALUE_BITS-1:0]    rd_val;
    logic [VALUE_BITS-1:0]    old_val;
    logic [TOTAL_W-1:0]       sum_one;
    logic [TOTAL_W+CNT_W-1:0] prod_all;
    logic [TOTAL_W-1:0]       n_total;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [WORD_W-1:0]        ram_wdata;

    // register values above the depth count as the full array
    assign count = (r_cfg > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : r_cfg;
    assign bad   = (r_op == OP_SET_ONE) && ({1'b0, r_idx} >= count);

    assign rd_gen  = rdata[WORD_W-1:VALUE_BITS];
    assign rd_val  = rdata[VALUE_BITS-1:0];
    // a stale entry reads as the last set-all value
    assign old_val = (rd_gen == r_gen) ? rd_val : r_gval;
    assign sum_one = r_total + TOTAL_W'(r_val) - TOTAL_W'(old_val);
    assign prod_all = TOTAL_W'(r_val) * (TOTAL_W+CNT_W)'(count);

    always_comb begin
        if (r_op == OP_SET_ALL) begin
            n_total = prod_all[TOTAL_W-1:0];
        end else if (bad) begin
            n_total = r_total;
        end else begin
            n_total = sum_one;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {r_gen, r_val};
        if (i_cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (i_cmd.exec && (r_op == OP_SET_ONE) && !bad) begin
            ram_we = 1'b1;
        end
    end

    assign o_stat.clear_last = (r_clr_addr == IDX_W'(ENTRIES - 1));

    apgas_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (i_index),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_cfg      <= CNT_W'(CFG_RST);
            r_gen      <= GEN_W'(1);
            r_gval     <= '0;
            r_total    <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_total <= n_total;
                if (r_op == OP_SET_ALL) begin
                    r_gen  <= r_gen + GEN_W'(1);
                    r_gval <= r_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_operation;
            r_idx <= i_index;
            r_val <= i_value;
        end
        if (i_cmd.exec) begin
            r_out_total <= n_total;
            r_out_bad   <= bad;
        end
    end

    assign o_done      = r_done;
    assign o_total     = r_out_total;
    assign o_bad_index = r_out_bad;

endmodule
`default_nettype wire

>>> sv/array_point_and_global_assign_sum_core.sv
`default_nettype none
// value array with a one-step set-all and a running total of the entries in use
//
// input: drive i_operation, i_index and i_value with i_start high; the word is
// taken at a clock edge where i_start is high and o_busy is low
// set one (operation 0) writes one entry; set all (operation 1) gives every
// entry in use the same value through a generation count
// result: o_total and o_bad_index are valid for the single cycle in which
// o_done is high; the receiver cannot hold a result off
// o_done is registered: it is set from the exec state entered at the accepting edge
// one word at a time: o_busy stays high until the word is applied, set by the
// read-then-write of the registered-read entry memory (read, then apply and write back)
// i_cfg_we with i_cfg_wdata writes entries_in_use; write it only while idle
// reset: synchronous, active low; afterwards a clearing pass zeroes the entry
// memory one entry a cycle, all ENTRIES entries (1024 by default), with o_busy high
// entries_in_use resets to 1024 (or ENTRIES if smaller), the total to zero
module array_point_and_global_assign_sum_core #(
    parameter int ENTRIES    = apgas_pkg::ENTRIES_DEF,
    parameter int VALUE_BITS = apgas_pkg::VALUE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [$clog2(ENTRIES):0]         i_cfg_wdata,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic                             i_operation,
    input  wire logic [$clog2(ENTRIES)-1:0]       i_index,
    input  wire logic [VALUE_BITS-1:0]            i_value,
    output logic                                  o_done,
    output logic [VALUE_BITS+$clog2(ENTRIES)-1:0] o_total,
    output logic                                  o_bad_index
);
    import apgas_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    apgas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    apgas_dp #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_operation (i_operation),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_total     (o_total),
        .o_bad_index (o_bad_index)
    );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import apgas_pkg::*;

    localparam int ENTRIES   = ENTRIES_DEF;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int VAL_W     = VALUE_BITS_DEF;
    localparam int TOTAL_W   = VAL_W + IDX_W;
    localparam int CFG_W     = IDX_W + 1;
    localparam int SHOW_MAX  = 10;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 75;

    // one pending word for the driver, or an entries_in_use write
    typedef struct {
        bit                 is_cfg;
        logic [CFG_W-1:0]   in_use;
        logic               op;
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   val;
        int unsigned        gap;
    } t_word_req;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               bad;
    } t_sum_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;
    logic               i_start     = 1'b0;
    logic               i_operation = 1'b0;
    logic [IDX_W-1:0]   i_index     = '0;
    logic [VAL_W-1:0]   i_value     = '0;
    logic               o_busy;
    logic               o_done;
    logic [TOTAL_W-1:0] o_total;
    logic               o_bad_index;

    array_point_and_global_assign_sum_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_operation (i_operation),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_total     (o_total),
        .o_bad_index (o_bad_index)
    );

    // predicted array state
    logic [VAL_W-1:0]   arr_value [ENTRIES];
    logic [31:0]        arr_gen   [ENTRIES];
    logic [31:0]        gen_now    = 32'd1;
    logic [VAL_W-1:0]   fill_value = '0;
    logic [TOTAL_W-1:0] sum_now    = '0;
    logic [CFG_W-1:0]   arr_in_use = CFG_W'(CFG_RESET_VAL);

    t_word_req          words_to_send [$];
    t_sum_result        totals_due [$];
    int                 issued_words   = 0;
    int                 accepted_words = 0;
    int unsigned        gap_left       = 0;
    int                 calm_cycles    = 0;
    int                 fault_count    = 0;
    int unsigned        gap_max        = 0;

    function automatic t_sum_result sum_after_word(logic op, logic [IDX_W-1:0] idx,
                                                   logic [VAL_W-1:0] val);
        t_sum_result      r;
        logic [CFG_W-1:0] live;
        logic [VAL_W-1:0] prior;
        live  = (arr_in_use > CFG_W'(ENTRIES)) ? CFG_W'(ENTRIES) : arr_in_use;
        r.bad = 1'b0;
        if (op == OP_SET_ALL) begin
            gen_now    = gen_now + 32'd1;
            fill_value = val;
            sum_now    = TOTAL_W'(live) * TOTAL_W'(val);
        end else if (CFG_W'(idx) >= live) begin
            r.bad = 1'b1;
        end else begin
            // a stale entry still holds the last set-all value
            prior          = (arr_gen[idx] == gen_now) ? arr_value[idx] : fill_value;
            sum_now        = sum_now + TOTAL_W'(val) - TOTAL_W'(prior);
            arr_value[idx] = val;
            arr_gen[idx]   = gen_now;
        end
        r.total = sum_now;
        return r;
    endfunction

    task automatic note_fault(string msg);
        fault_count++;
        if (fault_count <= SHOW_MAX) begin
            $display("%s", msg);
        end
    endtask

    task automatic queue_word(logic op, int idx, logic [VAL_W-1:0] val);
        t_word_req w;
        w.is_cfg = 1'b0;
        w.in_use = '0;
        w.op     = op;
        w.idx    = IDX_W'(idx);
        w.val    = val;
        w.gap    = $urandom_range(0, gap_max);
        words_to_send = {words_to_send, w};
    endtask

    task automatic queue_cfg(int n);
        t_word_req w;
        w.is_cfg = 1'b1;
        w.in_use = CFG_W'(n);
        w.op     = OP_SET_ONE;
        w.idx    = '0;
        w.val    = '0;
        w.gap    = 0;
        words_to_send = {words_to_send, w};
    endtask

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin : drive
        logic      nxt_start;
        logic      nxt_we;
        t_word_req head;
        nxt_start = 1'b0;
        nxt_we    = 1'b0;
        // config writes wait for quiet cycles with nothing in flight
        if (totals_due.size() == 0 && o_busy === 1'b0 && i_start == 1'b0) begin
            calm_cycles++;
        end else begin
            calm_cycles = 0;
        end
        if (!i_rst_n) begin
            calm_cycles = 0;
        end else if (issued_words != accepted_words) begin
            nxt_start = 1'b1;
        end else if (gap_left != 0) begin
            gap_left--;
        end else if (words_to_send.size() != 0) begin
            head = words_to_send[0];
            if (!head.is_cfg) begin
                void'(words_to_send.pop_front());
                i_operation <= head.op;
                i_index     <= head.idx;
                i_value     <= head.val;
                nxt_start   = 1'b1;
                issued_words++;
                gap_left    = head.gap;
            end else if (calm_cycles >= 3) begin
                void'(words_to_send.pop_front());
                i_cfg_wdata <= head.in_use;
                nxt_we      = 1'b1;
                calm_cycles = 0;
            end
        end
        i_start  <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    always @(posedge i_clk) begin : watch
        t_sum_result want;
        t_sum_result got;
        if (i_rst_n) begin
            // a result leaving now belongs to an older word than any taken now
            if (o_done === 1'b1) begin
                got.total = o_total;
                got.bad   = o_bad_index;
                if (totals_due.size() == 0) begin
                    note_fault($sformatf("unexpected result total %h bad_index %b",
                                         got.total, got.bad));
                end else begin
                    want = totals_due.pop_front();
                    if (got.total !== want.total || got.bad !== want.bad) begin
                        note_fault($sformatf(
                            "mismatch: total exp %h got %h, bad_index exp %b got %b",
                            want.total, got.total, want.bad, got.bad));
                    end
                end
            end
            if (i_cfg_we) begin
                arr_in_use = i_cfg_wdata;
            end
            if (i_start && o_busy === 1'b0) begin
                accepted_words++;
                totals_due = {totals_due, sum_after_word(i_operation, i_index, i_value)};
            end
        end
    end

    initial begin : stimulus
        int               plan [PHASES];
        int               live;
        int               pick;
        int               last_idx;
        logic [VAL_W-1:0] v;

        foreach (arr_gen[i]) begin
            arr_gen[i]   = '0;
            arr_value[i] = '0;
        end

        // directed part
        gap_max = 1;
        queue_word(OP_SET_ONE, 0, '0);
        queue_word(OP_SET_ONE, ENTRIES - 1, '1);
        queue_word(OP_SET_ONE, 5, 32'h1234_5678);
        queue_word(OP_SET_ONE, 5, 32'h0000_0001);
        queue_word(OP_SET_ALL, ENTRIES - 1, '1);
        queue_word(OP_SET_ONE, ENTRIES - 1, '0);
        queue_word(OP_SET_ONE, 3, '1);
        queue_word(OP_SET_ALL, 0, '0);
        queue_word(OP_SET_ONE, 7, 32'hAAAA_AAAA);
        queue_word(OP_SET_ONE, 7, 32'h5555_5555);
        queue_cfg(1);
        queue_word(OP_SET_ONE, 0, 32'd7);
        queue_word(OP_SET_ONE, 1, 32'd9);
        queue_word(OP_SET_ONE, ENTRIES - 1, '1);
        queue_word(OP_SET_ALL, 0, '1);
        // grow the count without a recompute: stale entries pull the total below zero
        queue_cfg(ENTRIES);
        queue_word(OP_SET_ONE, 500, '0);
        queue_word(OP_SET_ONE, 600, '0);
        queue_cfg(0);
        queue_word(OP_SET_ONE, 0, 32'd1);
        queue_word(OP_SET_ALL, 0, 32'd9);
        queue_cfg((1 << CFG_W) - 1);
        queue_word(OP_SET_ONE, ENTRIES - 1, 32'd3);
        queue_word(OP_SET_ALL, 0, '1);

        // random part, one entries_in_use setting per phase
        plan[0] = ENTRIES;
        plan[1] = 3;
        plan[2] = $urandom_range(4, ENTRIES - 1);
        plan[3] = (1 << CFG_W) - 1;
        plan[4] = 0;
        plan[5] = 1;
        plan[6] = $urandom_range(0, (1 << CFG_W) - 1);
        plan[7] = ENTRIES;
        last_idx = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            queue_cfg(plan[ph]);
            live    = (plan[ph] > ENTRIES) ? ENTRIES : plan[ph];
            gap_max = (ph % 3 == 1) ? 0 : 11;
            for (int k = 0; k < PHASE_LEN; k++) begin
                case ($urandom_range(0, 7))
                    0: v = '0;
                    1: v = '1;
                    default: v = $urandom;
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    queue_word(OP_SET_ALL, $urandom_range(0, ENTRIES - 1), v);
                end else begin
                    if (live == 0 || $urandom_range(0, 9) == 0) begin
                        pick = $urandom_range(0, ENTRIES - 1);
                    end else if ($urandom_range(0, 3) == 0 && last_idx < live) begin
                        // back-to-back hits on one entry
                        pick = last_idx;
                    end else begin
                        pick = $urandom_range(0, live - 1);
                    end
                    last_idx = pick;
                    queue_word(OP_SET_ONE, pick, v);
                end
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() != 0 || issued_words != accepted_words
               || totals_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("array_point_and_global_assign_sum_core verification clean");
        end else begin
            $display("array_point_and_global_assign_sum_core verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("array_point_and_global_assign_sum_core verification failed");
        $finish;
    end

endmodule

>>> array_point_and_global_assign_sum_core.f
sv/apgas_pkg.sv
sv/apgas_ram.sv
sv/apgas_ctrl.sv
sv/apgas_dp.sv
sv/array_point_and_global_assign_sum_core.sv
tb/tb_top.sv
